// File: rtl/decaying_spatial_loudness_map_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the loudness map unit
// Each use sits on a line of its own at the end of the module it concerns.
// ----------------------------------------------------------------------------
`ifndef DECAYING_SPATIAL_LOUDNESS_MAP_UNIT_ASSERT_SVH
`define DECAYING_SPATIAL_LOUDNESS_MAP_UNIT_ASSERT_SVH

// same-cycle implication
`define DSLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dslm_pkg.sv
// ----------------------------------------------------------------------------
// dslm_pkg
// Shared sizes, codes, command and configuration types of the loudness map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dslm_pkg;

  localparam int MaxGroups   = 4;
  localparam int FreqBins    = 64;
  localparam int SpatialBins = 180;
  localparam int CellBits    = 24;

  // field widths of the item ports
  localparam int GroupW   = 2;
  localparam int FreqW    = 6;
  localparam int SpatialW = 8;
  localparam int DataW    = 24;
  localparam int CoefW    = 16;

  localparam int CellDepth = 2 * MaxGroups * FreqBins * SpatialBins;
  localparam int AddrW     = $clog2(CellDepth);

  localparam int GroupCntW = $clog2(MaxGroups + 1);
  localparam int FreqCntW  = $clog2(FreqBins + 1);

  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [1:0] {
    OP_SWEEP = 2'd0,
    OP_OBS   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BELOW  = 3'd1,
    ST_DIRECT = 3'd2,
    ST_MASKED = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CUTOFF       = 3'd0,
    CFG_DIRECT_DECAY = 3'd1,
    CFG_MASKED_DECAY = 3'd2,
    CFG_MASK_RATIO   = 3'd3,
    CFG_GROUPS       = 3'd4,
    CFG_FREQ_BINS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_SWEEP,
    CMD_RANGE,
    CMD_OBS_ADD,
    CMD_OBS_BELOW,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   plane;
    logic [AddrW-1:0]       addr;
    logic [DataW-1:0]       intensity;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0]       cutoff;
    logic [CoefW-1:0]       direct_decay;
    logic [CoefW-1:0]       masked_decay;
    logic [CoefW-1:0]       mask_ratio;
    logic [GroupCntW-1:0]   groups;
    logic [FreqCntW-1:0]    freq_bins;
  } cfg_t;

  // flat cell address: plane, group, bin, spatial position
  function automatic logic [AddrW-1:0] cell_addr(logic p, logic [GroupW-1:0] g,
                                                 logic [FreqW-1:0] f,
                                                 logic [SpatialW-1:0] s);
    logic [AddrW-1:0] row;
    row = (AddrW'(p) * AddrW'(MaxGroups) + AddrW'(g)) * AddrW'(FreqBins) + AddrW'(f);
    return row * AddrW'(SpatialBins) + AddrW'(s);
  endfunction

endpackage

// File: rtl/decaying_spatial_loudness_map_unit.sv
// ----------------------------------------------------------------------------
// decaying_spatial_loudness_map_unit
// Two-plane decaying loudness map with observation, read and decay sweep.
// ----------------------------------------------------------------------------
// After reset the unit clears all 92160 cells of its memory, one per cycle,
// and holds full high meanwhile; configuration writes are taken throughout.
// Items are then classified on entry and queued (four deep), and the back end
// works through them one at a time against a single cell memory with one read
// and one write port: an observation or a read reads its cell, then, once the
// result register is free, loads the result and, for an observation above the
// cutoff, adds and writes back; an item out of range skips the memory; a decay
// sweep does one active cell per cycle, 2 * groups * bins * 180 in all. The
// oldest result sits in an output register until popped; input keeps queueing.
`timescale 1ns / 1ps

module decaying_spatial_loudness_map_unit import dslm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           operation_i,
  input  logic [GroupW-1:0]    group_i,
  input  logic [FreqW-1:0]     freq_bin_i,
  input  logic [SpatialW-1:0]  spatial_bin_i,
  input  logic [DataW-1:0]     intensity_i,
  input  logic [DataW-1:0]     loudness_i,
  input  logic [DataW-1:0]     partial_loudness_i,
  input  logic                 read_masked_plane_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [DataW-1:0]     cell_value_o,
  output logic                 above_cutoff_o,
  output logic [2:0]           status_o
);

  logic [DataW-1:0]  cutoff_q;
  logic [CoefW-1:0]  direct_decay_q;
  logic [CoefW-1:0]  masked_decay_q;
  logic [CoefW-1:0]  mask_ratio_q;
  logic [2:0]        groups_q;
  logic [6:0]        freq_bins_q;
  cfg_t              cfg;

  logic              q_full, q_wr, q_rd, q_valid, clearing;
  cmd_t              q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q       <= DataW'(6000);
      direct_decay_q <= CoefW'(55705);
      masked_decay_q <= CoefW'(39322);
      mask_ratio_q   <= CoefW'(696);
      groups_q       <= 3'd4;
      freq_bins_q    <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CUTOFF:       cutoff_q       <= cfg_data_i[DataW-1:0];
        CFG_DIRECT_DECAY: direct_decay_q <= cfg_data_i[CoefW-1:0];
        CFG_MASKED_DECAY: masked_decay_q <= cfg_data_i[CoefW-1:0];
        CFG_MASK_RATIO:   mask_ratio_q   <= cfg_data_i[CoefW-1:0];
        CFG_GROUPS:       groups_q       <= cfg_data_i[2:0];
        CFG_FREQ_BINS:    freq_bins_q    <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // counts above the built-in size mean the whole size
  always_comb begin
    cfg.cutoff       = cutoff_q;
    cfg.direct_decay = direct_decay_q;
    cfg.masked_decay = masked_decay_q;
    cfg.mask_ratio   = mask_ratio_q;
    cfg.groups       = (32'(groups_q) > MaxGroups) ? GroupCntW'(MaxGroups)
                                                   : GroupCntW'(groups_q);
    cfg.freq_bins    = (32'(freq_bins_q) > FreqBins) ? FreqCntW'(FreqBins)
                                                     : FreqCntW'(freq_bins_q);
  end

  assign full = q_full || clearing;

  dslm_front u_front (
    .push                (push),
    .full_i              (full),
    .operation_i         (operation_i),
    .group_i             (group_i),
    .freq_bin_i          (freq_bin_i),
    .spatial_bin_i       (spatial_bin_i),
    .intensity_i         (intensity_i),
    .loudness_i          (loudness_i),
    .partial_loudness_i  (partial_loudness_i),
    .read_masked_plane_i (read_masked_plane_i),
    .cfg_i               (cfg),
    .cmd_wr_o            (q_wr),
    .cmd_o               (q_in)
  );

  dslm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .data_i  (q_in),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  dslm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_out),
    .cmd_pop_o      (q_rd),
    .clearing_o     (clearing),
    .empty          (empty),
    .pop            (pop),
    .cell_value_o   (cell_value_o),
    .above_cutoff_o (above_cutoff_o),
    .status_o       (status_o)
  );

endmodule

// File: rtl/dslm_front.sv
// ----------------------------------------------------------------------------
// dslm_front
// Takes input items, checks the index, runs the masking test and the cutoff
// test and turns each item into a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dslm_front import dslm_pkg::*; (
  input  logic                 push,
  input  logic                 full_i,
  input  logic [1:0]           operation_i,
  input  logic [GroupW-1:0]    group_i,
  input  logic [FreqW-1:0]     freq_bin_i,
  input  logic [SpatialW-1:0]  spatial_bin_i,
  input  logic [DataW-1:0]     intensity_i,
  input  logic [DataW-1:0]     loudness_i,
  input  logic [DataW-1:0]     partial_loudness_i,
  input  logic                 read_masked_plane_i,
  input  cfg_t                 cfg_i,
  output logic                 cmd_wr_o,
  output cmd_t                 cmd_o
);

  logic [DataW+CoefW-1:0] loud_scaled;
  logic [DataW+CoefW-1:0] part_scaled;
  logic                   mask_hit;
  logic                   out_of_range;
  logic                   plane;

  assign cmd_wr_o = push && !full_i;

  // loudness * 256 > partial * ratio stands in for the log difference test
  assign loud_scaled = (DataW+CoefW)'({loudness_i, 8'b0});
  assign part_scaled = (DataW+CoefW)'(partial_loudness_i) * (DataW+CoefW)'(cfg_i.mask_ratio);
  assign mask_hit    = loud_scaled > part_scaled;

  assign out_of_range = (GroupCntW'(group_i) >= cfg_i.groups) ||
                        (FreqCntW'(freq_bin_i) >= cfg_i.freq_bins) ||
                        ((SpatialW+1)'(spatial_bin_i) >= (SpatialW+1)'(SpatialBins));

  assign plane = (operation_i == OP_OBS) ? mask_hit : read_masked_plane_i;

  always_comb begin
    cmd_o.plane     = plane;
    cmd_o.addr      = cell_addr(plane, group_i, freq_bin_i, spatial_bin_i);
    cmd_o.intensity = intensity_i;
    priority if (operation_i == OP_SWEEP) begin
      cmd_o.kind = CMD_SWEEP;
    end else if (out_of_range) begin
      cmd_o.kind = CMD_RANGE;
    end else if (operation_i == OP_OBS) begin
      cmd_o.kind = (intensity_i > cfg_i.cutoff) ? CMD_OBS_ADD : CMD_OBS_BELOW;
    end else begin
      // the unused operation code reads like a read
      cmd_o.kind = CMD_READ;
    end
  end

endmodule

// File: rtl/dslm_cmd_queue.sv
// ----------------------------------------------------------------------------
// dslm_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "decaying_spatial_loudness_map_unit_assert.svh"

module dslm_cmd_queue import dslm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t                slot_q [CmdDepth];
  logic [CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CmdCntW'(CmdDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = wr_ptr_q + CmdPtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = rd_ptr_q + CmdPtrW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CmdCntW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `DSLM_ASSERT_IMP(a_q_no_overflow, wr_i, !full_o, "command queue written while full")
  `DSLM_ASSERT_IMP(a_q_no_underflow, rd_i, valid_o, "command queue read while empty")
  `DSLM_ASSERT_NXT(a_q_count_up, wr_i && !rd_i, cnt_q == $past(cnt_q) + CmdCntW'(1), "queue count lost a write")

endmodule

// File: rtl/dslm_back.sv
// ----------------------------------------------------------------------------
// dslm_back
// Owns the cell memory: clears it after reset, runs observations above the
// cutoff as read-modify-write, reads other items plainly, runs the decay
// sweep one cell a cycle, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "decaying_spatial_loudness_map_unit_assert.svh"

module dslm_back import dslm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                clearing_o,
  output logic                empty,
  input  logic                pop,
  output logic [DataW-1:0]    cell_value_o,
  output logic                above_cutoff_o,
  output logic [2:0]          status_o
);

  typedef enum logic [4:0] {
    BK_CLEAR = 5'b00001,
    BK_IDLE  = 5'b00010,
    BK_RD    = 5'b00100,
    BK_SWEEP = 5'b01000,
    BK_DRAIN = 5'b10000
  } bk_state_e;

  bk_state_e state_q, state_d;

  logic [CellBits-1:0] cell_mem_q [CellDepth];
  logic [CellBits-1:0] rd_data_q;

  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_wa, mem_ra;
  logic [CellBits-1:0] mem_wd;

  cmd_t                cur_q, cur_d;
  logic [AddrW-1:0]    clr_addr_q, clr_addr_d;

  logic                sw_p_q, sw_p_d;
  logic [GroupW-1:0]   sw_g_q, sw_g_d;
  logic [FreqW-1:0]    sw_f_q, sw_f_d;
  logic [SpatialW-1:0] sw_s_q, sw_s_d;
  logic [AddrW-1:0]    sweep_addr;
  logic                s_last, f_last, g_last, sweep_last, sweep_none;

  logic                pipe_v_q, pipe_v_d;
  logic                pipe_p_q, pipe_p_d;
  logic [AddrW-1:0]    pipe_addr_q, pipe_addr_d;
  logic [CellBits+CoefW-1:0] decay_prod;

  logic [CellBits:0]   add_sum;
  logic [CellBits-1:0] add_sat;

  logic                res_valid_q;
  logic [DataW-1:0]    res_value_q;
  logic                res_above_q;
  logic [2:0]          res_status_q;
  logic                res_load;
  logic [CellBits-1:0] res_value;
  status_e             res_status;
  logic                slot_free;

  assign clearing_o     = state_q == BK_CLEAR;
  assign empty          = !res_valid_q;
  assign cell_value_o   = res_value_q;
  assign above_cutoff_o = res_above_q;
  assign status_o       = res_status_q;
  assign slot_free      = !res_valid_q || pop;

  assign sweep_addr = cell_addr(sw_p_q, sw_g_q, sw_f_q, sw_s_q);
  assign s_last     = (SpatialW+1)'(sw_s_q) == (SpatialW+1)'(SpatialBins - 1);
  assign f_last     = FreqCntW'(sw_f_q) == cfg_i.freq_bins - FreqCntW'(1);
  assign g_last     = GroupCntW'(sw_g_q) == cfg_i.groups - GroupCntW'(1);
  assign sweep_last = sw_p_q && g_last && f_last && s_last;
  assign sweep_none = (cfg_i.groups == '0) || (cfg_i.freq_bins == '0);

  assign decay_prod = (CellBits+CoefW)'(rd_data_q) *
                      (CellBits+CoefW)'(pipe_p_q ? cfg_i.masked_decay : cfg_i.direct_decay);

  assign add_sum = (CellBits+1)'(rd_data_q) + (CellBits+1)'(cur_q.intensity);
  assign add_sat = add_sum[CellBits] ? {CellBits{1'b1}} : add_sum[CellBits-1:0];

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    clr_addr_d  = clr_addr_q;
    sw_p_d      = sw_p_q;
    sw_g_d      = sw_g_q;
    sw_f_d      = sw_f_q;
    sw_s_d      = sw_s_q;
    pipe_v_d    = 1'b0;
    pipe_p_d    = sw_p_q;
    pipe_addr_d = sweep_addr;
    cmd_pop_o   = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = cmd_i.addr;
    mem_we      = 1'b0;
    mem_wa      = pipe_addr_q;
    mem_wd      = decay_prod[CellBits+CoefW-1:CoefW];
    res_load    = 1'b0;
    res_value   = '0;
    res_status  = ST_OK;

    // decayed cell goes back in the cycle after its read
    if (pipe_v_q) begin
      mem_we = 1'b1;
    end

    unique case (state_q)
      BK_CLEAR: begin
        mem_we     = 1'b1;
        mem_wa     = clr_addr_q;
        mem_wd     = '0;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(CellDepth - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        sw_p_d = 1'b0;
        sw_g_d = '0;
        sw_f_d = '0;
        sw_s_d = '0;
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_SWEEP: begin
              if (!sweep_none) begin
                cmd_pop_o = 1'b1;
                state_d   = BK_SWEEP;
              end else if (slot_free) begin
                cmd_pop_o = 1'b1;
                res_load  = 1'b1;
              end
            end
            CMD_RANGE: begin
              if (slot_free) begin
                cmd_pop_o  = 1'b1;
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            CMD_OBS_ADD, CMD_OBS_BELOW, CMD_READ: begin
              cmd_pop_o = 1'b1;
              mem_re    = 1'b1;
              cur_d     = cmd_i;
              state_d   = BK_RD;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_RD: begin
        if (slot_free) begin
          res_load = 1'b1;
          state_d  = BK_IDLE;
          unique case (cur_q.kind)
            CMD_OBS_ADD: begin
              mem_we     = 1'b1;
              mem_wa     = cur_q.addr;
              mem_wd     = add_sat;
              res_value  = add_sat;
              res_status = cur_q.plane ? ST_MASKED : ST_DIRECT;
            end
            CMD_OBS_BELOW: begin
              res_value  = rd_data_q;
              res_status = ST_BELOW;
            end
            default: begin
              res_value  = rd_data_q;
              res_status = ST_OK;
            end
          endcase
        end
      end
      BK_SWEEP: begin
        mem_re   = 1'b1;
        mem_ra   = sweep_addr;
        pipe_v_d = 1'b1;
        if (sweep_last) begin
          state_d = BK_DRAIN;
        end
        // spatial bin runs fastest, then frequency bin, group, plane
        if (!s_last) begin
          sw_s_d = sw_s_q + SpatialW'(1);
        end else begin
          sw_s_d = '0;
          if (!f_last) begin
            sw_f_d = sw_f_q + FreqW'(1);
          end else begin
            sw_f_d = '0;
            if (!g_last) begin
              sw_g_d = sw_g_q + GroupW'(1);
            end else begin
              sw_g_d = '0;
              sw_p_d = 1'b1;
            end
          end
        end
      end
      BK_DRAIN: begin
        if (slot_free) begin
          res_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      sw_p_q      <= 1'b0;
      sw_g_q      <= '0;
      sw_f_q      <= '0;
      sw_s_q      <= '0;
      pipe_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      sw_p_q     <= sw_p_d;
      sw_g_q     <= sw_g_d;
      sw_f_q     <= sw_f_d;
      sw_s_q     <= sw_s_d;
      pipe_v_q   <= pipe_v_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    pipe_p_q    <= pipe_p_d;
    pipe_addr_q <= pipe_addr_d;
    if (res_load) begin
      res_value_q  <= DataW'(res_value);
      res_above_q  <= res_value > cfg_i.cutoff;
      res_status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= cell_mem_q[mem_ra];
    end
  end

  `DSLM_ASSERT_IMP(a_bk_no_cmd_in_clear, state_q == BK_CLEAR, !cmd_pop_o, "command taken during clearing pass")
  `DSLM_ASSERT_IMP(a_bk_result_slot, res_load, !res_valid_q || pop, "result overwrote a waiting result")
  `DSLM_ASSERT_IMP(a_bk_rw_apart, mem_we && mem_re, mem_wa != mem_ra, "cell read and written at one address")
  `DSLM_ASSERT_NXT(a_bk_drain_writes, state_q == BK_SWEEP && state_d == BK_DRAIN, pipe_v_q, "last swept cell not written back")

endmodule
